// ===== sv/sha256_byte_stream_hasher_defines.svh =====
// Assertion macros used by the hasher's RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define SBH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sha256bsh_pkg.sv =====
// Types, constants and round functions for the SHA-256 byte stream hasher.
package sha256bsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    logic        length_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sbh_state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [1:0] LAST_IDX = 2'd3;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== sv/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream: byte packing, padding sequencer and one round unit.
// Each word carries at most one message byte; a word with last set closes the message, and
// the 256-bit digest then leaves as four 64-bit words, most significant first. A byte that
// does not complete a 64-byte block is taken without a stall. The byte that completes a block
// starts a compression on the single round unit: the rounds, then a fold of the result
// into the hash words, during which no word is taken. On last, the padding is fed through
// the same byte path one byte per cycle between compressions (the 0x80 byte, zero fill and
// eight length bytes, 9 to 72 bytes in all), with one or two compressions, after which the
// four digest words are offered one per cycle as the receiver allows. A bit length beyond
// 64 bits wraps and raises length_overflow on all four digest words.
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  sha256bsh_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sha256bsh_pkg::out_item_t out_item
);
  import sha256bsh_pkg::*;

  sbh_state_t  state_r, state_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  logic [23:0] acc_r, acc_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bit_length_r, bit_length_nxt;
  logic        overflow_r, overflow_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [1:0]  widx_r, widx_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        final_r, final_nxt;
  logic        ret_pad_r, ret_pad_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic        blk_done;
  logic [31:0] word_new;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [64:0] len_sum;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Length bytes go out big-endian at block positions 56 to 63.
  assign len_byte = 8'(bit_length_r >> {~fill_r[2:0], 3'b000});

  // Byte source: the input channel when idle, the padding sequencer in ST_PAD, none in other states.
  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    case (state_r)
      ST_IDLE: begin
        push_en   = in_acc && in_item.has_byte;
        push_byte = in_item.data_byte;
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_r) begin
          push_byte = PAD_BYTE;
        end else if (len_ok_r && (fill_r >= LEN_POS)) begin
          push_byte = len_byte;
        end else begin
          push_byte = 8'h00;
        end
      end
      default: begin
        push_en   = 1'b0;
        push_byte = 8'h00;
      end
    endcase
  end

  assign blk_done = push_en && (fill_r == LAST_POS);
  assign word_new = {acc_r, push_byte};

  // Round unit and message schedule.
  assign sched_new = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
  assign t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + SHA_K[rnd_r] + win_r[0];
  assign t2 = big_sigma0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign len_sum = {1'b0, bit_length_r} + 65'd8;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (blk_done) begin
          state_nxt = ST_ROUND;
        end else if (in_acc && in_item.last) begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (blk_done) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (ret_pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && (widx_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall                 = (state_r != ST_IDLE);
    out_valid                = (state_r == ST_OUT);
    out_item.digest_word     = {hash_r[{widx_r, 1'b0}], hash_r[{widx_r, 1'b1}]};
    out_item.word_index      = widx_r;
    out_item.last_word       = (widx_r == LAST_IDX);
    out_item.length_overflow = overflow_r;
  end

  // Datapath.
  always_comb begin
    hash_nxt       = hash_r;
    v_nxt          = v_r;
    win_nxt        = win_r;
    acc_nxt        = acc_r;
    fill_nxt       = fill_r;
    bit_length_nxt = bit_length_r;
    overflow_nxt   = overflow_r;
    rnd_nxt        = rnd_r;
    widx_nxt       = widx_r;
    pad_first_nxt  = pad_first_r;
    len_ok_nxt     = len_ok_r;
    final_nxt      = final_r;
    ret_pad_nxt    = ret_pad_r;

    if (push_en) begin
      acc_nxt  = word_new[23:0];
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = word_new;
      end
    end

    if (blk_done) begin
      v_nxt   = hash_r;
      rnd_nxt = '0;
    end

    case (state_r)
      ST_IDLE: begin
        if (push_en) begin
          bit_length_nxt = len_sum[63:0];
          overflow_nxt   = overflow_r | len_sum[64];
        end
        if (in_acc && in_item.last) begin
          pad_first_nxt = 1'b1;
          final_nxt     = 1'b0;
        end
        if (blk_done) begin
          ret_pad_nxt = in_item.last;
        end
      end
      ST_PAD: begin
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          // The length fits in this block only if the marker lands before its last eight bytes.
          len_ok_nxt = (fill_r < LEN_POS);
        end
        if (blk_done) begin
          ret_pad_nxt = 1'b1;
          len_ok_nxt  = 1'b1;
          final_nxt   = !pad_first_r && len_ok_r;
        end
      end
      ST_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = sched_new;
        rnd_nxt     = rnd_r + 6'd1;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        widx_nxt = '0;
      end
      ST_OUT: begin
        if (out_acc) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == LAST_IDX) begin
            hash_nxt       = SHA_IV;
            bit_length_nxt = '0;
            overflow_nxt   = 1'b0;
            final_nxt      = 1'b0;
            ret_pad_nxt    = 1'b0;
          end
        end
      end
      default: begin
        rnd_nxt = rnd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hash_r       <= SHA_IV;
      fill_r       <= '0;
      bit_length_r <= '0;
      overflow_r   <= 1'b0;
      rnd_r        <= '0;
      widx_r       <= '0;
      pad_first_r  <= 1'b0;
      len_ok_r     <= 1'b0;
      final_r      <= 1'b0;
      ret_pad_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hash_r       <= hash_nxt;
      fill_r       <= fill_nxt;
      bit_length_r <= bit_length_nxt;
      overflow_r   <= overflow_nxt;
      rnd_r        <= rnd_nxt;
      widx_r       <= widx_nxt;
      pad_first_r  <= pad_first_nxt;
      len_ok_r     <= len_ok_nxt;
      final_r      <= final_nxt;
      ret_pad_r    <= ret_pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    win_r <= win_nxt;
    acc_r <= acc_nxt;
  end

  // A digest is only ever shown once the padded message has ended on a block boundary.
  `SBH_ASSERT_NOW(a_out_aligned, out_valid, fill_r == 6'd0, "digest shown mid-block")
  `SBH_ASSERT_NEXT(a_round_end, (state_r == ST_ROUND) && (rnd_r == LAST_RND), state_r == ST_ADD, "round count overran")
  `SBH_ASSERT_NEXT(a_restart, out_acc && (widx_r == LAST_IDX), (state_r == ST_IDLE) && (bit_length_r == 64'd0) && !overflow_r, "no reinitialisation after digest")
  `SBH_ASSERT_NEXT(a_bare_last, in_acc && in_item.last && !in_item.has_byte, state_r == ST_PAD, "bare last did not start padding")

endmodule
